// ----- rtl/core/grc_pkg.sv -----
// Shared constants, types and helpers of the grid ray wall caster.
`default_nettype none
package grc_pkg;

   // Map geometry
   localparam int MAP_COLUMNS    = 64;
   localparam int MAP_ROWS       = 64;
   localparam int MAP_DEPTH      = MAP_COLUMNS * MAP_ROWS;
   localparam int ADDR_W         = $clog2(MAP_DEPTH);
   localparam int COORD_W        = 10;
   localparam int WALK_BOUND     = MAP_COLUMNS + MAP_ROWS + 4;
   localparam int STEP_W         = $clog2(WALK_BOUND + 1);

   // Arithmetic widths
   localparam int KIND_W         = 3;
   localparam int POS_W          = 22;
   localparam int DIR_W          = 16;
   localparam int UNIT_W         = 30;
   localparam int LEN_W          = 40;
   localparam int DIST_W         = 24;
   localparam int TEX_W          = 16;
   localparam int COL_OUT_W      = 10;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // Request operations
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   // Wall side codes
   localparam logic [1:0] SIDE_XNEG = 2'd0;
   localparam logic [1:0] SIDE_YPOS = 2'd1;
   localparam logic [1:0] SIDE_XPOS = 2'd2;
   localparam logic [1:0] SIDE_YNEG = 2'd3;

   typedef logic signed [COORD_W-1:0] coord_type;

   // One cell of movement along an axis
   localparam coord_type CELL_ONE = coord_type'(1);

   // Linear map address of a cell
   function automatic logic [ADDR_W-1:0] cell_addr(input coord_type cx, input coord_type cy);
      logic [31:0] a;
      a = 32'(unsigned'(cy)) * 32'(MAP_ROWS > 0 ? MAP_COLUMNS : 1) + 32'(unsigned'(cx));
      return a[ADDR_W-1:0];
   endfunction

   // Cell lies inside the map
   function automatic logic in_map(input coord_type cx, input coord_type cy);
      return (cx >= 0) && (cy >= 0) &&
             (cx < coord_type'(MAP_COLUMNS)) && (cy < coord_type'(MAP_ROWS));
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/grid_ray_wall_caster_top.sv -----
// Top level: request decode, DDA walk sequencer and result register.
//
// After reset the block sweeps the map to empty, one cell a cycle, with busy high. A write
// request gives no result. A cast request with both direction components zero goes straight
// to the result; any other cast runs the reciprocal unit once per nonzero direction
// component, two setup multiplies, then per cell entered a step, one map read and a check
// (plus up to two neighbor reads at a diagonal corner), and last forms the result, which
// shows on the next cycle. The map memory port sets the walking rate. The result is shown
// for one cycle with rsp_valid and must be taken then; busy is low again in that cycle.
`default_nettype none
module grid_ray_wall_caster_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_operation,
   input  wire logic [5:0]                      req_cell_column,
   input  wire logic [5:0]                      req_cell_row,
   input  wire logic [grc_pkg::KIND_W-1:0]      req_cell_kind,
   input  wire logic [grc_pkg::POS_W-1:0]       req_start_x,
   input  wire logic [grc_pkg::POS_W-1:0]       req_start_y,
   input  wire logic signed [grc_pkg::DIR_W-1:0] req_dir_x,
   input  wire logic signed [grc_pkg::DIR_W-1:0] req_dir_y,
   input  wire logic [grc_pkg::COL_OUT_W-1:0]   req_column_index,
   output logic                                 rsp_valid,
   output logic      [grc_pkg::COL_OUT_W-1:0]   rsp_column_out,
   output logic      [grc_pkg::DIST_W-1:0]      rsp_ray_distance,
   output logic      [1:0]                      rsp_wall_side,
   output logic      [grc_pkg::KIND_W-1:0]      rsp_hit_kind,
   output logic      [grc_pkg::TEX_W-1:0]       rsp_texture_u,
   output logic                                 rsp_hit
);

   typedef enum logic [12:0] {
      ST_CLEAR = 13'b0000000000001,
      ST_IDLE  = 13'b0000000000010,
      ST_DIVX  = 13'b0000000000100,
      ST_DIVY  = 13'b0000000001000,
      ST_MULX  = 13'b0000000010000,
      ST_MULY  = 13'b0000000100000,
      ST_STEP  = 13'b0000001000000,
      ST_READ  = 13'b0000010000000,
      ST_CHECK = 13'b0000100000000,
      ST_NB1   = 13'b0001000000000,
      ST_NB2   = 13'b0010000000000,
      ST_TEX   = 13'b0100000000000,
      ST_FIN   = 13'b1000000000000
   } state_type;

   localparam int FR_W = 17;
   localparam int MAGP_W = 29;

   state_type                         state_ff, state_in;
   logic [grc_pkg::ADDR_W-1:0]        clr_ff, clr_in;
   logic [grc_pkg::POS_W-1:0]         sx_ff, sx_in, sy_ff, sy_in;
   logic [grc_pkg::DIR_W-1:0]         dxmag_ff, dxmag_in, dymag_ff, dymag_in;
   logic                              dxneg_ff, dxneg_in, dyneg_ff, dyneg_in;
   logic                              xinf_ff, xinf_in, yinf_ff, yinf_in;
   logic                              none_ff, none_in;
   logic [grc_pkg::COL_OUT_W-1:0]     col_ff, col_in;
   logic [grc_pkg::UNIT_W-1:0]        ux_ff, ux_in, uy_ff, uy_in;
   logic [grc_pkg::LEN_W-1:0]         lx_ff, lx_in, ly_ff, ly_in;
   grc_pkg::coord_type                cx_ff, cx_in, cy_ff, cy_in;
   logic [grc_pkg::LEN_W-1:0]         dist_ff, dist_in;
   logic [1:0]                        side_ff, side_in;
   logic                              corner_ff, corner_in;
   logic [grc_pkg::STEP_W-1:0]        steps_ff, steps_in;
   logic [grc_pkg::KIND_W-1:0]        nbk_ff, nbk_in, kind_ff, kind_in;
   logic                              hit_ff, hit_in;
   logic [MAGP_W-1:0]                 mag_ff, mag_in;
   logic                              div_run_ff, div_run_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [grc_pkg::COL_OUT_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [grc_pkg::DIST_W-1:0]        rsp_dist_ff, rsp_dist_in;
   logic [1:0]                        rsp_side_ff, rsp_side_in;
   logic [grc_pkg::KIND_W-1:0]        rsp_kind_ff, rsp_kind_in;
   logic [grc_pkg::TEX_W-1:0]         rsp_tex_ff, rsp_tex_in;
   logic                              rsp_hit_ff, rsp_hit_in;

   logic                              accept;
   logic                              ram_we;
   logic [grc_pkg::ADDR_W-1:0]        ram_waddr, ram_raddr;
   logic [grc_pkg::KIND_W-1:0]        ram_wdata, ram_rdata;
   logic                              div_start, div_done;
   logic [grc_pkg::DIR_W-1:0]         div_divisor;
   logic [grc_pkg::UNIT_W-1:0]        div_quo;
   grc_pkg::coord_type                nb1_cx, nb2_cy, wr_cx, wr_cy;
   logic [FR_W-1:0]                   frac_x, frac_y;
   logic [grc_pkg::UNIT_W+FR_W-1:0]   prod_len;
   logic [grc_pkg::DIR_W+MAGP_W-1:0]  prod_mag;
   logic                              x_less, y_less;
   logic [grc_pkg::DIR_W-1:0]         sel_mag;
   logic                              sel_neg;
   logic [grc_pkg::TEX_W-1:0]         along, pos, tex;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // map write port: clearing sweep or write request
   assign wr_cx = grc_pkg::coord_type'(req_cell_column);
   assign wr_cy = grc_pkg::coord_type'(req_cell_row);
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = accept && (req_operation == grc_pkg::OP_WRITE) &&
                     grc_pkg::in_map(wr_cx, wr_cy);
         ram_waddr = grc_pkg::cell_addr(wr_cx, wr_cy);
         ram_wdata = req_cell_kind;
      end
   end

   // neighbor cells of a corner step
   assign nb1_cx = dxneg_ff ? cx_ff + grc_pkg::CELL_ONE : cx_ff - grc_pkg::CELL_ONE;
   assign nb2_cy = dyneg_ff ? cy_ff + grc_pkg::CELL_ONE : cy_ff - grc_pkg::CELL_ONE;

   // map read address
   always_comb begin
      case (state_ff)
         ST_READ:  ram_raddr = grc_pkg::cell_addr(cx_ff, cy_ff);
         ST_CHECK: ram_raddr = grc_pkg::cell_addr(nb1_cx, cy_ff);
         ST_NB1:   ram_raddr = grc_pkg::cell_addr(cx_ff, nb2_cy);
         default:  ram_raddr = '0;
      endcase
   end

   grc_map_ram u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign div_divisor = (state_ff == ST_DIVX) ? dxmag_ff : dymag_ff;

   grc_recip_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // datapath terms
   assign frac_x  = dxneg_ff ? {1'b0, sx_ff[15:0]} : FR_W'(17'h10000 - {1'b0, sx_ff[15:0]});
   assign frac_y  = dyneg_ff ? {1'b0, sy_ff[15:0]} : FR_W'(17'h10000 - {1'b0, sy_ff[15:0]});
   assign prod_len = (state_ff == ST_MULX) ? ux_ff * frac_x : uy_ff * frac_y;
   assign x_less  = !xinf_ff && (yinf_ff || (lx_ff < ly_ff));
   assign y_less  = !yinf_ff && (xinf_ff || (ly_ff < lx_ff));
   assign sel_mag = side_ff[0] ? dxmag_ff : dymag_ff;
   assign sel_neg = side_ff[0] ? dxneg_ff : dyneg_ff;
   assign along   = side_ff[0] ? sx_ff[15:0] : sy_ff[15:0];
   assign prod_mag = sel_mag * dist_ff[MAGP_W-1:0];
   assign pos     = sel_neg ? along - mag_ff[MAGP_W-1:13] : along + mag_ff[MAGP_W-1:13];
   assign tex     = side_ff[1] ? pos : grc_pkg::TEX_W'(0) - pos;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      dxmag_in   = dxmag_ff;
      dymag_in   = dymag_ff;
      dxneg_in   = dxneg_ff;
      dyneg_in   = dyneg_ff;
      xinf_in    = xinf_ff;
      yinf_in    = yinf_ff;
      none_in    = none_ff;
      col_in     = col_ff;
      ux_in      = ux_ff;
      uy_in      = uy_ff;
      lx_in      = lx_ff;
      ly_in      = ly_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      dist_in    = dist_ff;
      side_in    = side_ff;
      corner_in  = corner_ff;
      steps_in   = steps_ff;
      nbk_in     = nbk_ff;
      kind_in    = kind_ff;
      hit_in     = hit_ff;
      mag_in     = mag_ff;
      div_run_in = div_run_ff;
      div_start  = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_col_in   = rsp_col_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_side_in  = rsp_side_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tex_in   = rsp_tex_ff;
      rsp_hit_in   = rsp_hit_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == grc_pkg::ADDR_W'(grc_pkg::MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_operation == grc_pkg::OP_CAST)) begin
               sx_in     = req_start_x;
               sy_in     = req_start_y;
               dxneg_in  = req_dir_x[grc_pkg::DIR_W-1];
               dyneg_in  = req_dir_y[grc_pkg::DIR_W-1];
               dxmag_in  = req_dir_x[grc_pkg::DIR_W-1] ? 16'(-req_dir_x) : req_dir_x;
               dymag_in  = req_dir_y[grc_pkg::DIR_W-1] ? 16'(-req_dir_y) : req_dir_y;
               xinf_in   = (req_dir_x == '0);
               yinf_in   = (req_dir_y == '0);
               none_in   = (req_dir_x == '0) && (req_dir_y == '0);
               col_in    = req_column_index;
               cx_in     = grc_pkg::coord_type'(req_start_x[21:16]);
               cy_in     = grc_pkg::coord_type'(req_start_y[21:16]);
               dist_in   = '0;
               side_in   = grc_pkg::SIDE_XNEG;
               kind_in   = '0;
               hit_in    = 1'b0;
               steps_in  = '0;
               corner_in = 1'b0;
               mag_in    = '0;
               state_in  = ((req_dir_x == '0) && (req_dir_y == '0)) ? ST_FIN : ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (xinf_ff) begin
               state_in = ST_DIVY;
            end else if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               ux_in      = div_quo;
               div_run_in = 1'b0;
               state_in   = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (yinf_ff) begin
               state_in = ST_MULX;
            end else if (!div_run_ff) begin
               div_start  = 1'b1;
               div_run_in = 1'b1;
            end else if (div_done) begin
               uy_in      = div_quo;
               div_run_in = 1'b0;
               state_in   = ST_MULX;
            end
         end
         ST_MULX: begin
            lx_in    = grc_pkg::LEN_W'(prod_len >> 16);
            state_in = ST_MULY;
         end
         ST_MULY: begin
            ly_in    = grc_pkg::LEN_W'(prod_len >> 16);
            state_in = ST_STEP;
         end
         // one DDA step along the nearer boundary
         ST_STEP: begin
            if (steps_ff == grc_pkg::STEP_W'(grc_pkg::WALK_BOUND)) begin
               state_in = ST_TEX;
            end else begin
               steps_in  = steps_ff + 1'b1;
               corner_in = 1'b0;
               state_in  = ST_READ;
               if (x_less) begin
                  dist_in = lx_ff;
                  lx_in   = lx_ff + grc_pkg::LEN_W'(ux_ff);
                  cx_in   = dxneg_ff ? cx_ff - grc_pkg::CELL_ONE : cx_ff + grc_pkg::CELL_ONE;
                  side_in = dxneg_ff ? grc_pkg::SIDE_XNEG : grc_pkg::SIDE_XPOS;
               end else if (y_less) begin
                  dist_in = ly_ff;
                  ly_in   = ly_ff + grc_pkg::LEN_W'(uy_ff);
                  cy_in   = dyneg_ff ? cy_ff - grc_pkg::CELL_ONE : cy_ff + grc_pkg::CELL_ONE;
                  side_in = dyneg_ff ? grc_pkg::SIDE_YNEG : grc_pkg::SIDE_YPOS;
               end else begin
                  corner_in = 1'b1;
                  dist_in   = lx_ff;
                  lx_in     = lx_ff + grc_pkg::LEN_W'(ux_ff);
                  ly_in     = ly_ff + grc_pkg::LEN_W'(uy_ff);
                  cx_in     = dxneg_ff ? cx_ff - grc_pkg::CELL_ONE : cx_ff + grc_pkg::CELL_ONE;
                  cy_in     = dyneg_ff ? cy_ff - grc_pkg::CELL_ONE : cy_ff + grc_pkg::CELL_ONE;
                  side_in   = dxneg_ff ? grc_pkg::SIDE_XNEG : grc_pkg::SIDE_XPOS;
               end
            end
         end
         ST_READ: begin
            state_in = grc_pkg::in_map(cx_ff, cy_ff) ? ST_CHECK : ST_TEX;
         end
         ST_CHECK: begin
            if (ram_rdata != '0) begin
               kind_in  = ram_rdata;
               hit_in   = 1'b1;
               state_in = ST_TEX;
            end else begin
               state_in = corner_ff ? ST_NB1 : ST_STEP;
            end
         end
         ST_NB1: begin
            if (grc_pkg::in_map(nb1_cx, cy_ff) && (ram_rdata != '0)) begin
               nbk_in   = ram_rdata;
               state_in = ST_NB2;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_NB2: begin
            if (grc_pkg::in_map(cx_ff, nb2_cy) && (ram_rdata != '0)) begin
               kind_in  = nbk_ff;
               hit_in   = 1'b1;
               state_in = ST_TEX;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_TEX: begin
            mag_in   = prod_mag[MAGP_W-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = col_ff;
            rsp_dist_in  = (dist_ff > grc_pkg::LEN_W'(grc_pkg::DIST_MAX)) ?
                           grc_pkg::DIST_MAX : dist_ff[grc_pkg::DIST_W-1:0];
            rsp_side_in  = side_ff;
            rsp_kind_in  = kind_ff;
            rsp_tex_in   = none_ff ? '0 : tex;
            rsp_hit_in   = hit_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         div_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         div_run_ff   <= div_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      dxmag_ff  <= dxmag_in;
      dymag_ff  <= dymag_in;
      dxneg_ff  <= dxneg_in;
      dyneg_ff  <= dyneg_in;
      xinf_ff   <= xinf_in;
      yinf_ff   <= yinf_in;
      none_ff   <= none_in;
      col_ff    <= col_in;
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      lx_ff     <= lx_in;
      ly_ff     <= ly_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      dist_ff   <= dist_in;
      side_ff   <= side_in;
      corner_ff <= corner_in;
      steps_ff  <= steps_in;
      nbk_ff    <= nbk_in;
      kind_ff   <= kind_in;
      hit_ff    <= hit_in;
      mag_ff    <= mag_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_side_ff <= rsp_side_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tex_ff  <= rsp_tex_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_out   = rsp_col_ff;
   assign rsp_ray_distance = rsp_dist_ff;
   assign rsp_wall_side    = rsp_side_ff;
   assign rsp_hit_kind     = rsp_kind_ff;
   assign rsp_texture_u    = rsp_tex_ff;
   assign rsp_hit          = rsp_hit_ff;

endmodule
`default_nettype wire

// ----- rtl/core/grc_map_ram.sv -----
// Map cell memory: one write port, one registered read port.
`default_nettype none
module grc_map_ram (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [grc_pkg::ADDR_W-1:0]   wr_addr,
   input  wire logic [grc_pkg::KIND_W-1:0]   wr_data,
   input  wire logic [grc_pkg::ADDR_W-1:0]   rd_addr,
   output logic      [grc_pkg::KIND_W-1:0]   rd_data
);

   logic [grc_pkg::KIND_W-1:0] mem [grc_pkg::MAP_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/core/grc_recip_div.sv -----
// Bit-serial reciprocal unit: quotient of 2^29 by a 16-bit magnitude.
`default_nettype none
module grc_recip_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [grc_pkg::DIR_W-1:0]     divisor,
   output logic                               done,
   output logic      [grc_pkg::UNIT_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(grc_pkg::UNIT_W);

   logic                          run_ff,  run_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff,  cnt_in;
   logic [grc_pkg::DIR_W-1:0]     rem_ff,  rem_in;
   logic [grc_pkg::DIR_W-1:0]     div_ff,  div_in;
   logic [grc_pkg::UNIT_W-1:0]    quo_ff,  quo_in;
   logic [grc_pkg::DIR_W:0]       trial;
   logic                          num_bit;

   // one quotient bit per cycle, restoring
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      num_bit = (cnt_ff == CNT_W'(grc_pkg::UNIT_W - 1));
      trial   = {rem_ff, num_bit};
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(grc_pkg::UNIT_W - 1);
         rem_in = '0;
         div_in = divisor;
         quo_in = '0;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = grc_pkg::DIR_W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[grc_pkg::UNIT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[grc_pkg::DIR_W-1:0];
            quo_in = {quo_ff[grc_pkg::UNIT_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the grid ray wall caster: map writes, DDA casts, result checks.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                             op;
      logic [5:0]                       col;
      logic [5:0]                       row;
      logic [grc_pkg::KIND_W-1:0]       kind;
      logic [grc_pkg::POS_W-1:0]        sx;
      logic [grc_pkg::POS_W-1:0]        sy;
      logic signed [grc_pkg::DIR_W-1:0] dx;
      logic signed [grc_pkg::DIR_W-1:0] dy;
      logic [grc_pkg::COL_OUT_W-1:0]    colidx;
   } request_type;

   typedef struct {
      logic [grc_pkg::COL_OUT_W-1:0] col;
      logic [grc_pkg::DIST_W-1:0]    ray_len;
      logic [1:0]                    side;
      logic [grc_pkg::KIND_W-1:0]    kind;
      logic [grc_pkg::TEX_W-1:0]     tex;
      logic                          hit;
   } ray_result_type;

   localparam longint unsigned INFINITE_LEN = 64'd1 << 62;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                             req_operation    = grc_pkg::OP_WRITE;
   logic [5:0]                       req_cell_column  = '0;
   logic [5:0]                       req_cell_row     = '0;
   logic [grc_pkg::KIND_W-1:0]       req_cell_kind    = '0;
   logic [grc_pkg::POS_W-1:0]        req_start_x      = '0;
   logic [grc_pkg::POS_W-1:0]        req_start_y      = '0;
   logic signed [grc_pkg::DIR_W-1:0] req_dir_x        = '0;
   logic signed [grc_pkg::DIR_W-1:0] req_dir_y        = '0;
   logic [grc_pkg::COL_OUT_W-1:0]    req_column_index = '0;
   logic                             rsp_valid;
   logic [grc_pkg::COL_OUT_W-1:0]    rsp_column_out;
   logic [grc_pkg::DIST_W-1:0]       rsp_ray_distance;
   logic [1:0]                       rsp_wall_side;
   logic [grc_pkg::KIND_W-1:0]       rsp_hit_kind;
   logic [grc_pkg::TEX_W-1:0]        rsp_texture_u;
   logic                             rsp_hit;

   grid_ray_wall_caster_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_cell_column(req_cell_column),
      .req_cell_row(req_cell_row), .req_cell_kind(req_cell_kind),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y),
      .req_column_index(req_column_index),
      .rsp_valid(rsp_valid), .rsp_column_out(rsp_column_out),
      .rsp_ray_distance(rsp_ray_distance), .rsp_wall_side(rsp_wall_side),
      .rsp_hit_kind(rsp_hit_kind), .rsp_texture_u(rsp_texture_u), .rsp_hit(rsp_hit)
   );

   request_type    pending_q[$];
   ray_result_type expected_q[$];
   logic [grc_pkg::KIND_W-1:0] grid_model[grc_pkg::MAP_DEPTH];
   int mismatches = 0;
   int casts_sent = 0;
   int writes_sent = 0;
   int rays_hit = 0;
   int rays_checked = 0;
   int burst_left = 4;
   int gap_left = 0;

   // Clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Model grid lookup, outside counts as empty
   function automatic logic [grc_pkg::KIND_W-1:0] grid_kind(input int cx, input int cy);
      if (cx < 0 || cy < 0 || cx >= grc_pkg::MAP_COLUMNS || cy >= grc_pkg::MAP_ROWS) return '0;
      return grid_model[cy * grc_pkg::MAP_COLUMNS + cx];
   endfunction

   // Step length and first boundary distance of one axis
   function automatic void axis_prep(input logic [grc_pkg::POS_W-1:0] pos, input int d,
                                     output int stp, output longint unsigned unit,
                                     output longint unsigned len);
      longint unsigned frac;
      frac = pos[15:0];
      if (d == 0) begin
         stp = 0;
         unit = INFINITE_LEN;
         len = INFINITE_LEN;
      end else begin
         unit = (64'd1 << 29) / longint'(d < 0 ? -d : d);
         stp = d < 0 ? -1 : 1;
         len = d < 0 ? (unit * frac) >> 16 : (unit * (65536 - frac)) >> 16;
      end
   endfunction

   // DDA walk over the model grid
   function automatic ray_result_type cast_ray(input request_type r);
      ray_result_type res;
      int dx, dy, stx, sty, cx, cy, d;
      longint unsigned ux, uy, lx, ly, ray_len, mag;
      longint pos;
      logic [1:0] side;
      logic corner;
      logic [grc_pkg::TEX_W-1:0] tex;
      dx = r.dx;
      dy = r.dy;
      ray_len = 0;
      side = grc_pkg::SIDE_XNEG;
      res.col = r.colidx;
      res.kind = '0;
      res.hit = 1'b0;
      tex = '0;
      if (dx != 0 || dy != 0) begin
         axis_prep(r.sx, dx, stx, ux, lx);
         axis_prep(r.sy, dy, sty, uy, ly);
         cx = int'(r.sx >> 16);
         cy = int'(r.sy >> 16);
         for (int n = 0; n < grc_pkg::WALK_BOUND; n++) begin
            corner = 1'b0;
            if (lx < ly) begin
               ray_len = lx; lx += ux; cx += stx;
               side = stx == 1 ? grc_pkg::SIDE_XPOS : grc_pkg::SIDE_XNEG;
            end else if (lx > ly) begin
               ray_len = ly; ly += uy; cy += sty;
               side = sty == -1 ? grc_pkg::SIDE_YNEG : grc_pkg::SIDE_YPOS;
            end else begin
               corner = 1'b1;
               ray_len = lx; lx += ux; ly += uy; cx += stx; cy += sty;
               side = stx == 1 ? grc_pkg::SIDE_XPOS : grc_pkg::SIDE_XNEG;
            end
            if (cx < 0 || cy < 0 || cx >= grc_pkg::MAP_COLUMNS || cy >= grc_pkg::MAP_ROWS)
               break;
            if (grid_kind(cx, cy) != 0) begin
               res.kind = grid_kind(cx, cy);
               res.hit = 1'b1;
               break;
            end
            // diagonal squeeze between two solid neighbors
            if (corner && grid_kind(cx - stx, cy) != 0 && grid_kind(cx, cy - sty) != 0) begin
               res.kind = grid_kind(cx - stx, cy);
               res.hit = 1'b1;
               break;
            end
         end
         d = side[0] ? dx : dy;
         mag = (longint'(d < 0 ? -d : d) * ray_len) >> 13;
         pos = longint'(side[0] ? r.sx : r.sy);
         pos = d < 0 ? pos - longint'(mag) : pos + longint'(mag);
         tex = pos[15:0];
         if (side < 2) tex = -tex;
      end
      res.ray_len = ray_len > grc_pkg::DIST_MAX ? grc_pkg::DIST_MAX :
                    ray_len[grc_pkg::DIST_W-1:0];
      res.side = side;
      res.tex = tex;
      return res;
   endfunction

   // Driver: bursts of requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            if (pending_q[0].op == grc_pkg::OP_CAST) begin
               expected_q.push_back(cast_ray(pending_q[0]));
               casts_sent++;
            end else begin
               grid_model[pending_q[0].row * grc_pkg::MAP_COLUMNS + pending_q[0].col] =
                  pending_q[0].kind;
               writes_sent++;
            end
            void'(pending_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_q.size() > 0) begin
            start <= 1'b1;
            req_operation <= pending_q[0].op;
            req_cell_column <= pending_q[0].col;
            req_cell_row <= pending_q[0].row;
            req_cell_kind <= pending_q[0].kind;
            req_start_x <= pending_q[0].sx;
            req_start_y <= pending_q[0].sy;
            req_dir_x <= pending_q[0].dx;
            req_dir_y <= pending_q[0].dy;
            req_column_index <= pending_q[0].colidx;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: column %0d", rsp_column_out);
         end else begin
            rays_checked++;
            if (rsp_hit) rays_hit++;
            if (rsp_column_out !== expected_q[0].col ||
                rsp_ray_distance !== expected_q[0].ray_len ||
                rsp_wall_side !== expected_q[0].side || rsp_hit_kind !== expected_q[0].kind ||
                rsp_texture_u !== expected_q[0].tex || rsp_hit !== expected_q[0].hit) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp col %0d dist %0d side %0d kind %0d tex %0d hit %0d",
                           expected_q[0].col, expected_q[0].ray_len, expected_q[0].side,
                           expected_q[0].kind, expected_q[0].tex, expected_q[0].hit);
                  $display("          got col %0d dist %0d side %0d kind %0d tex %0d hit %0d",
                           rsp_column_out, rsp_ray_distance, rsp_wall_side, rsp_hit_kind,
                           rsp_texture_u, rsp_hit);
               end
            end
            void'(expected_q.pop_front());
         end
      end
   end

   function automatic void add_write(input int col, input int row, input int kind);
      request_type r;
      r = '{default: '0};
      r.op = grc_pkg::OP_WRITE;
      r.col = 6'(col);
      r.row = 6'(row);
      r.kind = grc_pkg::KIND_W'(kind);
      r.sx = grc_pkg::POS_W'($urandom);
      r.sy = grc_pkg::POS_W'($urandom);
      pending_q.push_back(r);
   endfunction

   function automatic void add_cast(input int sx, input int sy, input int dx, input int dy,
                                    input int colidx);
      request_type r;
      r = '{default: '0};
      r.op = grc_pkg::OP_CAST;
      r.sx = grc_pkg::POS_W'(sx);
      r.sy = grc_pkg::POS_W'(sy);
      r.dx = grc_pkg::DIR_W'(dx);
      r.dy = grc_pkg::DIR_W'(dy);
      r.colidx = grc_pkg::COL_OUT_W'(colidx);
      r.col = 6'($urandom_range(0, 63));
      r.row = 6'($urandom_range(0, 63));
      r.kind = grc_pkg::KIND_W'($urandom_range(0, 7));
      pending_q.push_back(r);
   endfunction

   // Random direction component, often small to reach saturation and long walks
   function automatic int rand_dir();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return int'($urandom_range(0, 64)) - 32;
         2: return $urandom_range(0, 1) ? 32767 : -32768;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Stimulus
   initial begin
      int s, d;
      for (int i = 0; i < grc_pkg::MAP_DEPTH; i++) grid_model[i] = '0;
      // directed: walls for a straight hit and a diagonal squeeze
      add_write(20, 10, 2);
      add_write(11, 10, 1);
      add_write(10, 11, 4);
      add_write(63, 63, 7);
      add_write(0, 0, 5);
      add_cast(10 << 16 | 16'h8000, 10 << 16 | 16'h4000, 8192, 0, 0);
      add_cast(10 << 16 | 16'h8000, 10 << 16 | 16'h8000, 8192, 8192, 1023);
      add_cast(10 << 16 | 16'h8000, 10 << 16 | 16'h8000, 0, 0, 5);
      add_cast(30 << 16, 30 << 16, 0, -8192, 6);
      add_cast(30 << 16, 30 << 16, 32767, 0, 7);
      add_cast(30 << 16, 30 << 16, -32768, -32768, 8);
      add_cast(4194303, 4194303, 1, 0, 9);
      add_cast(0, 0, 0, 1, 10);
      add_cast(16'h8000, 16'h8000, -8192, -8192, 11);
      add_cast(11 << 16 | 16'h8000, 10 << 16 | 16'h8000, -8192, 100, 12);
      add_cast(62 << 16, 62 << 16, 5000, 5000, 13);
      add_cast(32 << 16 | 16'h1234, 32 << 16 | 16'hFFFF, -1, 32767, 14);
      add_write(20, 10, 0);
      add_cast(10 << 16 | 16'h8000, 10 << 16 | 16'h4000, 8192, 0, 15);
      // random: build up walls, then mostly casts
      for (int i = 0; i < 450; i++) begin
         if (i < 60 || $urandom_range(0, 99) < 25) begin
            add_write($urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7));
         end else if ($urandom_range(0, 9) == 0) begin
            // equal magnitudes from a shared fraction force corner steps when the two signs agree
            s = $urandom_range(0, 65535);
            d = $urandom_range(1, 32767);
            add_cast($urandom_range(0, 63) << 16 | s, $urandom_range(0, 63) << 16 | s,
                     $urandom_range(0, 1) ? d : -d, $urandom_range(0, 1) ? d : -d,
                     $urandom_range(0, 1023));
         end else begin
            add_cast(int'($urandom_range(0, 4194303)), int'($urandom_range(0, 4194303)),
                     rand_dir(), rand_dir(), $urandom_range(0, 1023));
         end
      end
      while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("%0d map writes and %0d rays sent, %0d results checked, %0d rays hit a cell",
               writes_sent, casts_sent, rays_checked, rays_hit);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("[grid_ray_wall_caster_top] OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[grid_ray_wall_caster_top] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #30ms;
      $display("timeout with %0d requests and %0d results outstanding",
               pending_q.size(), expected_q.size());
      $display("[grid_ray_wall_caster_top] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
